>>> rtl/drim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drim_pkg: shared types and constants of the deleted-row index mapper
// Field widths, action and status codes, sequencer states and saturating add.
// ----------------------------------------------------------------------------
package drim_pkg;

	localparam int ROW_W             = 63;
	localparam int ACT_W             = 2;
	localparam int DELS_W            = 11;
	localparam int STAT_W            = 3;
	localparam int MAX_DELETIONS_DEF = 1024;

	typedef logic [ROW_W-1:0] row_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_CLEAR = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_MAP   = 2'd2,
		ACT_RANGE = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK         = 3'd0,
		STAT_FULL       = 3'd1,
		STAT_NOT_ASC    = 3'd2,
		STAT_END_BEFORE = 3'd3,
		STAT_EXCEED     = 3'd4
	} status_t;

	// Binary search engine states
	typedef enum logic [1:0] {
		RK_IDLE,
		RK_ADDR,
		RK_CMP,
		RK_DONE
	} rank_state_t;

	// Item sequencer states
	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_EXEC,
		SQ_MAP_START,
		SQ_MAP_WAIT,
		SQ_RG_END_START,
		SQ_RG_END_WAIT,
		SQ_RG_POS_START,
		SQ_RG_POS_WAIT,
		SQ_RG_CHECK,
		SQ_RG_ADD,
		SQ_EMIT
	} seq_state_t;

	// Search request from the sequencer to the rank engine
	typedef struct packed {
		logic start;
		logic or_equal;
	} rank_req_t;

	// Add two row values and clamp at the largest row value
	function automatic row_t sat_add_row(row_t a, row_t b);
		logic [ROW_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ROW_W] ? {ROW_W{1'b1}} : s[ROW_W-1:0];
	endfunction

endpackage

>>> rtl/drim_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drim_cmd_if: command channel
// Valid/ready channel that carries one action with its row operands.
// ----------------------------------------------------------------------------
interface drim_cmd_if;
	logic                      valid;
	logic                      ready;
	logic [drim_pkg::ACT_W-1:0] action;
	logic [drim_pkg::ROW_W-1:0] position;
	logic [drim_pkg::ROW_W-1:0] range_end;

	modport source (output valid, output action, output position, output range_end,
		input ready);
	modport sink (input valid, input action, input position, input range_end,
		output ready);
endinterface

>>> rtl/drim_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drim_res_if: result channel
// Valid/ready channel that carries one result per command.
// ----------------------------------------------------------------------------
interface drim_res_if;
	logic                        valid;
	logic                        ready;
	logic [drim_pkg::ROW_W-1:0]  mapped_index;
	logic [drim_pkg::ROW_W-1:0]  logical_end;
	logic [drim_pkg::DELS_W-1:0] deleted_in_range;
	logic [drim_pkg::STAT_W-1:0] status;

	modport source (output valid, output mapped_index, output logical_end,
		output deleted_in_range, output status, input ready);
	modport sink (input valid, input mapped_index, input logical_end,
		input deleted_in_range, input status, output ready);
endinterface

>>> rtl/drim_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drim_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module drim_ram #(
	parameter  int WIDTH  = 8,
	parameter  int DEPTH  = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/drim_rank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drim_rank: binary search rank engine
// Counts table entries below (or at or below) a key; each probe addresses the table in RK_ADDR and compares in RK_CMP.
// ----------------------------------------------------------------------------
module drim_rank #(
	parameter  int MAX_DELETIONS = drim_pkg::MAX_DELETIONS_DEF,
	localparam int CNT_W  = $clog2(MAX_DELETIONS + 1),
	localparam int ADDR_W = (MAX_DELETIONS > 1) ? $clog2(MAX_DELETIONS) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  drim_pkg::rank_req_t        req,
	input  logic [drim_pkg::ROW_W-1:0] key,
	input  logic [CNT_W-1:0]           count,
	output logic                       done,
	output logic [CNT_W-1:0]           rank,
	output logic [ADDR_W-1:0]          raddr,
	input  logic [drim_pkg::ROW_W-1:0] rdata
);
	import drim_pkg::*;

	rank_state_t      state_q, state_d;
	logic [CNT_W-1:0] lo_q, hi_q, lo_d, hi_d;
	logic [CNT_W-1:0] mid;
	row_t             key_q;
	logic             or_equal_q;
	logic             goes_left;

	// Probe the middle of the half-open interval
	assign mid   = lo_q + ((hi_q - lo_q) >> 1);
	assign raddr = mid[ADDR_W-1:0];
	assign rank  = lo_q;

	assign goes_left = or_equal_q ? (rdata <= key_q) : (rdata < key_q);

	// Next state and interval update
	always_comb begin
		state_d = state_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		done    = 1'b0;
		unique case (state_q)
			RK_IDLE: begin
				if (req.start) begin
					lo_d    = '0;
					hi_d    = count;
					state_d = (count != '0) ? RK_ADDR : RK_DONE;
				end
			end
			RK_ADDR: begin
				state_d = RK_CMP;
			end
			RK_CMP: begin
				if (goes_left) begin
					lo_d = mid + 1'b1;
				end else begin
					hi_d = mid;
				end
				state_d = (lo_d < hi_d) ? RK_ADDR : RK_DONE;
			end
			RK_DONE: begin
				done    = 1'b1;
				state_d = RK_IDLE;
			end
			default: state_d = RK_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the search interval and key
	always_ff @(posedge clk) begin
		lo_q <= lo_d;
		hi_q <= hi_d;
		if (state_q == RK_IDLE && req.start) begin
			key_q      <= key;
			or_equal_q <= req.or_equal;
		end
	end

endmodule

>>> rtl/drim_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drim_seq: item sequencer
// Runs clear, load, map and row-group actions over the rank engine and table.
// ----------------------------------------------------------------------------
module drim_seq #(
	parameter  int MAX_DELETIONS = drim_pkg::MAX_DELETIONS_DEF,
	localparam int CNT_W  = $clog2(MAX_DELETIONS + 1),
	localparam int ADDR_W = (MAX_DELETIONS > 1) ? $clog2(MAX_DELETIONS) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	drim_cmd_if.sink                   cmd,
	drim_res_if.source                 result,
	output drim_pkg::rank_req_t        rank_req,
	output logic [drim_pkg::ROW_W-1:0] rank_key,
	output logic [CNT_W-1:0]           rank_count,
	input  logic                       rank_done,
	input  logic [CNT_W-1:0]           rank_val,
	output logic                       we,
	output logic [ADDR_W-1:0]          waddr,
	output logic [drim_pkg::ROW_W-1:0] wdata
);
	import drim_pkg::*;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DELETIONS);

	seq_state_t        state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	row_t              offset_q;
	row_t              last_q;
	action_t           act_q;
	row_t              pos_q, rend_q;
	row_t              phys_q, rows_q, surv_q;
	logic [CNT_W-1:0]  r_end_q, d_q;
	row_t              st_mapped_q, st_lend_q;
	logic [DELS_W-1:0] st_dels_q;
	status_t           st_status_q;
	logic              out_valid_q;
	row_t              out_mapped_q, out_lend_q;
	logic [DELS_W-1:0] out_dels_q;
	status_t           out_status_q;
	logic              accept, emit, load_ok;
	row_t              map_next, rg_lend;

	assign accept  = cmd.valid && cmd.ready;
	assign emit    = (state_q == SQ_EMIT) && (!out_valid_q || result.ready);
	assign load_ok = (count_q != CNT_MAX) && !((count_q != '0) && (pos_q <= last_q));

	assign map_next = sat_add_row(pos_q, ROW_W'(rank_val));
	assign rg_lend  = sat_add_row(offset_q, surv_q);

	assign rank_count = count_q;
	assign waddr      = count_q[ADDR_W-1:0];
	assign wdata      = pos_q;

	assign result.valid            = out_valid_q;
	assign result.mapped_index     = out_mapped_q;
	assign result.logical_end      = out_lend_q;
	assign result.deleted_in_range = out_dels_q;
	assign result.status           = out_status_q;

	// Next state, search requests and table write
	always_comb begin
		state_d           = state_q;
		cmd.ready         = 1'b0;
		rank_req.start    = 1'b0;
		rank_req.or_equal = 1'b0;
		rank_key          = pos_q;
		we                = 1'b0;
		unique case (state_q)
			SQ_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					state_d = SQ_EXEC;
				end
			end
			SQ_EXEC: begin
				unique case (act_q)
					ACT_CLEAR: state_d = SQ_EMIT;
					ACT_LOAD: begin
						we      = load_ok;
						state_d = SQ_EMIT;
					end
					ACT_MAP: state_d = (count_q == '0) ? SQ_EMIT : SQ_MAP_START;
					ACT_RANGE: begin
						if (count_q == '0 || rend_q < pos_q) begin
							state_d = SQ_EMIT;
						end else begin
							state_d = SQ_RG_END_START;
						end
					end
					default: state_d = SQ_EMIT;
				endcase
			end
			SQ_MAP_START: begin
				rank_req.start    = 1'b1;
				rank_req.or_equal = 1'b1;
				rank_key          = phys_q;
				state_d           = SQ_MAP_WAIT;
			end
			SQ_MAP_WAIT: begin
				if (rank_done) begin
					state_d = (map_next == phys_q) ? SQ_EMIT : SQ_MAP_START;
				end
			end
			SQ_RG_END_START: begin
				rank_req.start = 1'b1;
				rank_key       = rend_q;
				state_d        = SQ_RG_END_WAIT;
			end
			SQ_RG_END_WAIT: begin
				if (rank_done) begin
					state_d = SQ_RG_POS_START;
				end
			end
			SQ_RG_POS_START: begin
				rank_req.start = 1'b1;
				rank_key       = pos_q;
				state_d        = SQ_RG_POS_WAIT;
			end
			SQ_RG_POS_WAIT: begin
				if (rank_done) begin
					state_d = SQ_RG_CHECK;
				end
			end
			SQ_RG_CHECK: begin
				state_d = (ROW_W'(d_q) > rows_q) ? SQ_EMIT : SQ_RG_ADD;
			end
			SQ_RG_ADD: begin
				state_d = SQ_EMIT;
			end
			SQ_EMIT: begin
				if (emit) begin
					state_d = SQ_IDLE;
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	// Control registers: state, table fill, running offset, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_IDLE;
			count_q     <= '0;
			offset_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == SQ_EXEC && act_q == ACT_CLEAR) begin
				count_q  <= '0;
				offset_q <= '0;
			end
			if (we) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == SQ_RG_ADD) begin
				offset_q <= rg_lend;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action_t'(cmd.action);
			pos_q  <= cmd.position;
			rend_q <= cmd.range_end;
		end
		if (we) begin
			last_q <= pos_q;
		end
		case (state_q)
			SQ_EXEC: begin
				st_mapped_q <= '0;
				st_lend_q   <= '0;
				st_dels_q   <= '0;
				st_status_q <= STAT_OK;
				phys_q      <= pos_q;
				rows_q      <= rend_q - pos_q;
				case (act_q)
					ACT_LOAD: begin
						if (count_q == CNT_MAX) begin
							st_status_q <= STAT_FULL;
						end else if (!load_ok) begin
							st_status_q <= STAT_NOT_ASC;
						end
					end
					ACT_MAP: begin
						if (count_q == '0) begin
							st_mapped_q <= pos_q;
						end
					end
					ACT_RANGE: begin
						if (count_q == '0) begin
							st_mapped_q <= pos_q;
							st_lend_q   <= rend_q;
						end else if (rend_q < pos_q) begin
							st_status_q <= STAT_END_BEFORE;
						end
					end
					default: ;
				endcase
			end
			SQ_MAP_WAIT: begin
				if (rank_done) begin
					// Stop at the fixed point, else retry with the new guess
					if (map_next == phys_q) begin
						st_mapped_q <= phys_q;
						st_dels_q   <= DELS_W'(rank_val);
					end else begin
						phys_q <= map_next;
					end
				end
			end
			SQ_RG_END_WAIT: begin
				if (rank_done) begin
					r_end_q <= rank_val;
				end
			end
			SQ_RG_POS_WAIT: begin
				if (rank_done) begin
					d_q <= r_end_q - rank_val;
				end
			end
			SQ_RG_CHECK: begin
				if (ROW_W'(d_q) > rows_q) begin
					st_status_q <= STAT_EXCEED;
				end
				surv_q <= rows_q - ROW_W'(d_q);
			end
			SQ_RG_ADD: begin
				st_mapped_q <= offset_q;
				st_lend_q   <= rg_lend;
				st_dels_q   <= DELS_W'(d_q);
			end
			default: ;
		endcase
		if (emit) begin
			out_mapped_q <= st_mapped_q;
			out_lend_q   <= st_lend_q;
			out_dels_q   <= st_dels_q;
			out_status_q <= st_status_q;
		end
	end

endmodule

>>> rtl/deleted_row_index_mapper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deleted_row_index_mapper_unit: deleted-row index mapper
// Keeps an ascending table of deleted rows and maps logical and physical rows.
//
//   channel  dir  handshake     payload
//   cmd      in   valid/ready   action, position, range_end
//   result   out  valid/ready   mapped_index, logical_end, deleted_in_range,
//                               status
//
// One command at a time; cmd.ready is high only while the sequencer is idle.
// A rank search over N stored rows is a binary search on the single table
// read port. After its transfer a clear or load passes SQ_EXEC and SQ_EMIT;
// a map adds up to N+1 back-to-back searches, a row group two searches and
// the SQ_RG_CHECK and SQ_RG_ADD states. cmd.ready rises with the result.
// Reset empties the table and zeroes the running offset; no clearing pass.
// A result waiting in the output register does not block the next transfer;
// the one after it holds in the sequencer until the waiting result transfers.
// ----------------------------------------------------------------------------
module deleted_row_index_mapper_unit #(
	parameter int MAX_DELETIONS = drim_pkg::MAX_DELETIONS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	drim_cmd_if.sink   cmd,
	drim_res_if.source result
);
	import drim_pkg::*;

	localparam int CNT_W  = $clog2(MAX_DELETIONS + 1);
	localparam int ADDR_W = (MAX_DELETIONS > 1) ? $clog2(MAX_DELETIONS) : 1;

	rank_req_t         rank_req;
	row_t              rank_key;
	logic [CNT_W-1:0]  rank_count;
	logic              rank_done;
	logic [CNT_W-1:0]  rank_val;
	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	row_t              wdata, rdata;

	// Deleted-row table
	drim_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAX_DELETIONS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Shared binary search engine
	drim_rank #(
		.MAX_DELETIONS (MAX_DELETIONS)
	) u_rank (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rank_req),
		.key    (rank_key),
		.count  (rank_count),
		.done   (rank_done),
		.rank   (rank_val),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	// Command sequencer
	drim_seq #(
		.MAX_DELETIONS (MAX_DELETIONS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.result     (result),
		.rank_req   (rank_req),
		.rank_key   (rank_key),
		.rank_count (rank_count),
		.rank_done  (rank_done),
		.rank_val   (rank_val),
		.we         (we),
		.waddr      (waddr),
		.wdata      (wdata)
	);

endmodule

>>> bench/drim_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drim_result_checker: result scoreboard for the deleted-row index mapper
// Watches the command and result channels. Keeps its own copy of the deleted
// row table and the running offset, predicts each result when its command
// transfers, and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module drim_result_checker #(
	parameter int MAX_DELETIONS = drim_pkg::MAX_DELETIONS_DEF
) (
	input logic  clk,
	input logic  arst_n,
	drim_cmd_if  cmd,
	drim_res_if  result,
	output int   mismatch_count,
	output int   pending_results
);
	import drim_pkg::*;

	typedef struct packed {
		row_t              mapped_index;
		row_t              logical_end;
		logic [DELS_W-1:0] deleted_in_range;
		status_t           status;
	} mapper_result_t;

	row_t           del_rows [MAX_DELETIONS];
	int unsigned    del_count;
	row_t           row_offset;
	mapper_result_t expected_results [$];
	mapper_result_t want;

	// Count stored deletions below x, or at or below x when incl is set
	function automatic int unsigned count_deleted(row_t x, bit incl);
		int unsigned lo, hi, mid;
		lo = 0;
		hi = del_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (incl ? (del_rows[mid] <= x) : (del_rows[mid] < x))
				lo = mid + 1;
			else
				hi = mid;
		end
		return lo;
	endfunction

	// Add two row values, clamp at the largest row value
	function automatic row_t clamp_add(row_t a, row_t b);
		logic [ROW_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ROW_W] ? {ROW_W{1'b1}} : s[ROW_W-1:0];
	endfunction

	// Apply one command to the local state and return its result
	function automatic mapper_result_t apply_command(action_t act, row_t pos, row_t rend);
		mapper_result_t r;
		row_t           phys, nxt, rows;
		int unsigned    n, d;
		int             g;
		bit             stable;
		r = '0;
		case (act)
			ACT_CLEAR: begin
				del_count  = 0;
				row_offset = '0;
			end
			ACT_LOAD: begin
				// full table wins over ordering
				if (del_count >= MAX_DELETIONS)
					r.status = STAT_FULL;
				else if (del_count > 0 && pos <= del_rows[del_count-1])
					r.status = STAT_NOT_ASC;
				else begin
					del_rows[del_count] = pos;
					del_count++;
				end
			end
			ACT_MAP: begin
				if (del_count == 0) begin
					r.mapped_index = pos;
				end else begin
					// iterate the guess until the deletion count stops moving it
					phys   = pos;
					n      = 0;
					stable = 1'b0;
					for (g = 0; g <= MAX_DELETIONS + 1 && !stable; g++) begin
						n   = count_deleted(phys, 1'b1);
						nxt = clamp_add(pos, row_t'(n));
						if (nxt == phys)
							stable = 1'b1;
						else
							phys = nxt;
					end
					r.mapped_index     = phys;
					r.deleted_in_range = n[DELS_W-1:0];
				end
			end
			default: begin
				if (del_count == 0) begin
					r.mapped_index = pos;
					r.logical_end  = rend;
				end else if (rend < pos) begin
					r.status = STAT_END_BEFORE;
				end else begin
					d    = count_deleted(rend, 1'b0) - count_deleted(pos, 1'b0);
					rows = rend - pos;
					if (row_t'(d) > rows) begin
						r.status = STAT_EXCEED;
					end else begin
						r.mapped_index     = row_offset;
						r.logical_end      = clamp_add(row_offset, rows - row_t'(d));
						r.deleted_in_range = d[DELS_W-1:0];
						row_offset         = r.logical_end;
					end
				end
			end
		endcase
		return r;
	endfunction

	// Print one line per mismatch (bounded) and count it
	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
		if (mismatch_count < 100)
			$display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
		mismatch_count++;
	endtask

	// Compare result transfers first, then predict the command transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			del_count       = 0;
			row_offset      = '0;
			mismatch_count  = 0;
			pending_results = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no command pending", result.mapped_index, '0);
				end else begin
					want = expected_results.pop_front();
					if (result.mapped_index !== want.mapped_index)
						report_mismatch("mapped_index", result.mapped_index, want.mapped_index);
					if (result.logical_end !== want.logical_end)
						report_mismatch("logical_end", result.logical_end, want.logical_end);
					if (result.deleted_in_range !== want.deleted_in_range)
						report_mismatch("deleted_in_range", result.deleted_in_range,
							want.deleted_in_range);
					if (result.status !== want.status)
						report_mismatch("status", result.status, want.status);
				end
			end
			if (cmd.valid && cmd.ready)
				expected_results.insert(expected_results.size(),
					apply_command(action_t'(cmd.action), cmd.position, cmd.range_end));
			pending_results = expected_results.size();
		end
	end

endmodule

>>> bench/tb_deleted_row_index_mapper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deleted_row_index_mapper_unit: testbench top of the deleted-row mapper
// Drives a directed set of corner commands, then random sessions of clear,
// ascending loads and map/range queries, with one full-table session. Both
// channels idle at random; the receiver holds off once for a long stretch.
// A separate scoreboard predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_deleted_row_index_mapper_unit;
	import drim_pkg::*;

	localparam int   MAX_DEL       = MAX_DELETIONS_DEF;
	localparam int   ITEM_TARGET   = 1650;
	localparam int   STALL_LIMIT   = 100000;
	localparam int   PRESSURE_HOLD = 400;
	localparam row_t ROW_MAX       = '1;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   pending_results;
	int   items_sent;
	int   idle_cycles = 0;
	bit   pressure_req;
	bit   burst_mode;
	bit   fill_done;
	row_t loaded_rows [$];

	drim_cmd_if cmd_ch ();
	drim_res_if res_ch ();

	deleted_row_index_mapper_unit #(.MAX_DELETIONS(MAX_DEL)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.result (res_ch)
	);

	drim_result_checker #(.MAX_DELETIONS(MAX_DEL)) u_scoreboard (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd_ch),
		.result          (res_ch),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	// Clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic row_t rand_row();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[ROW_W-1:0];
	endfunction

	// Small, near the top, or anywhere
	function automatic row_t pick_row();
		case ($urandom_range(0, 3))
			0:       return row_t'($urandom_range(0, 2000));
			1:       return ROW_MAX - row_t'($urandom_range(0, 2000));
			default: return rand_row();
		endcase
	endfunction

	function automatic row_t step_up(row_t a, row_t b);
		logic [ROW_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ROW_W] ? ROW_MAX : s[ROW_W-1:0];
	endfunction

	// Mostly land close to a stored deletion, otherwise anywhere
	function automatic row_t pick_query_row();
		row_t v, delta;
		if (loaded_rows.size() == 0 || $urandom_range(0, 9) < 4)
			return pick_row();
		v     = loaded_rows[$urandom_range(0, loaded_rows.size() - 1)];
		delta = row_t'($urandom_range(0, 3));
		if ($urandom_range(0, 1) == 0)
			return (v >= delta) ? v - delta : v;
		return step_up(v, delta);
	endfunction

	function automatic int pick_gap();
		int roll;
		if (burst_mode)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Offer one command after a random gap and hold it until it transfers
	task automatic send_cmd(action_t act, row_t pos, row_t rend);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.action    <= act;
		cmd_ch.position  <= pos;
		cmd_ch.range_end <= rend;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		items_sent++;
		// track table contents to steer later queries
		case (act)
			ACT_CLEAR: loaded_rows.delete();
			ACT_LOAD: begin
				if (loaded_rows.size() < MAX_DEL &&
						(loaded_rows.size() == 0 || pos > loaded_rows[$]))
					loaded_rows.insert(loaded_rows.size(), pos);
			end
			default: ;
		endcase
	endtask

	// Ascending loads with the odd duplicate or step back
	task automatic load_run(int count, int step_class);
		int   i;
		row_t v, step;
		for (i = 0; i < count; i++) begin
			if (loaded_rows.size() > 0 && $urandom_range(0, 9) == 0) begin
				v = loaded_rows[$urandom_range(0, loaded_rows.size() - 1)];
				send_cmd(ACT_LOAD, (v > 0 && $urandom_range(0, 1) == 1) ? v - 1 : v, rand_row());
			end else begin
				case (step_class)
					0:       step = row_t'($urandom_range(1, 3));
					1:       step = row_t'($urandom_range(1, 2000));
					default: step = row_t'({$urandom_range(1, 255), $urandom()});
				endcase
				if (loaded_rows.size() == 0)
					v = ($urandom_range(0, 3) == 0) ? pick_row() : row_t'($urandom_range(0, 50));
				else
					v = step_up(loaded_rows[$], step);
				send_cmd(ACT_LOAD, v, rand_row());
			end
		end
	endtask

	// Maps and row groups against the current table, some stray loads and clears
	task automatic query_run(int count);
		int   i, roll;
		row_t p, e;
		for (i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				send_cmd(ACT_MAP, pick_query_row(), rand_row());
			end else if (roll < 92) begin
				p = pick_query_row();
				case ($urandom_range(0, 9))
					0:          e = (p > 100) ? p - row_t'($urandom_range(1, 100)) : '0;
					1, 2, 3, 4: e = step_up(p, row_t'($urandom_range(0, 50)));
					5, 6, 7:    e = step_up(p, row_t'($urandom_range(0, 5000)));
					8:          e = step_up(p, row_t'({$urandom_range(0, 255), $urandom()}));
					default:    e = ($urandom_range(0, 1) == 0) ? ROW_MAX : pick_row();
				endcase
				send_cmd(ACT_RANGE, p, e);
			end else if (roll < 97) begin
				send_cmd(ACT_LOAD, pick_row(), rand_row());
			end else begin
				send_cmd(ACT_CLEAR, rand_row(), rand_row());
			end
		end
	endtask

	// One session: usually clear, load a few rows, then query
	task automatic run_session();
		int i, n_load;
		burst_mode = ($urandom_range(0, 4) == 0);
		if ($urandom_range(0, 19) == 0) begin
			for (i = 0; i < 10; i++)
				send_cmd(action_t'($urandom_range(0, 3)), rand_row(), rand_row());
		end else begin
			if (loaded_rows.size() > 100 || $urandom_range(0, 4) != 0)
				send_cmd(ACT_CLEAR, rand_row(), rand_row());
			n_load = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
			load_run(n_load, $urandom_range(0, 2));
			query_run($urandom_range(2, 10));
		end
		burst_mode = 1'b0;
	endtask

	// Fill the table densely, overflow it, and query the full table
	task automatic fill_table();
		send_cmd(ACT_CLEAR, rand_row(), rand_row());
		send_cmd(ACT_LOAD, '0, rand_row());
		while (loaded_rows.size() < MAX_DEL)
			send_cmd(ACT_LOAD, step_up(loaded_rows[$], row_t'($urandom_range(1, 3))), rand_row());
		repeat (3) send_cmd(ACT_LOAD, step_up(loaded_rows[$], row_t'($urandom_range(1, 9))),
			rand_row());
		send_cmd(ACT_LOAD, '0, rand_row());
		send_cmd(ACT_MAP, '0, rand_row());
		send_cmd(ACT_MAP, row_t'($urandom_range(0, 3000)), rand_row());
		send_cmd(ACT_MAP, ROW_MAX, rand_row());
		send_cmd(ACT_MAP, rand_row(), rand_row());
		send_cmd(ACT_RANGE, '0, ROW_MAX);
		send_cmd(ACT_RANGE, row_t'(100), row_t'(50));
		send_cmd(ACT_RANGE, row_t'(500), row_t'(1500));
		send_cmd(ACT_CLEAR, rand_row(), rand_row());
	endtask

	// Receiver: random stalls, stretches of steady ready, one long hold-off
	initial begin
		int roll, span;
		res_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (pressure_req) begin
				res_ch.ready <= 1'b0;
				repeat (PRESSURE_HOLD) @(posedge clk);
				pressure_req = 1'b0;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 10) begin
					res_ch.ready <= 1'b1;
					span = $urandom_range(40, 200);
				end else if (roll < 60) begin
					res_ch.ready <= 1'b1;
					span = $urandom_range(1, 6);
				end else if (roll < 95) begin
					res_ch.ready <= 1'b0;
					span = $urandom_range(1, 4);
				end else begin
					res_ch.ready <= 1'b0;
					span = $urandom_range(10, 60);
				end
				repeat (span) @(posedge clk);
			end
		end
	end

	// Watchdog: end the run when nothing transfers for too long
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus and verdict
	initial begin
		cmd_ch.valid     <= 1'b0;
		cmd_ch.action    <= ACT_CLEAR;
		cmd_ch.position  <= '0;
		cmd_ch.range_end <= '0;
		arst_n       = 1'b0;
		items_sent   = 0;
		pressure_req = 1'b0;
		burst_mode   = 1'b0;
		fill_done    = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: map and row group pass straight through
		send_cmd(ACT_MAP, ROW_MAX, rand_row());
		send_cmd(ACT_MAP, '0, '0);
		send_cmd(ACT_RANGE, ROW_MAX, '0);
		send_cmd(ACT_RANGE, row_t'(3), row_t'(1));
		// duplicate load, map onto a deletion at zero
		send_cmd(ACT_LOAD, '0, ROW_MAX);
		send_cmd(ACT_LOAD, '0, '0);
		send_cmd(ACT_MAP, '0, '0);
		send_cmd(ACT_CLEAR, ROW_MAX, ROW_MAX);
		// descending load, load at the top of the range
		send_cmd(ACT_LOAD, row_t'(10), '0);
		send_cmd(ACT_LOAD, row_t'(5), '0);
		send_cmd(ACT_LOAD, row_t'(20), '0);
		send_cmd(ACT_LOAD, ROW_MAX, '0);
		send_cmd(ACT_LOAD, ROW_MAX, '0);
		// map below, onto, and saturating past the deletions
		send_cmd(ACT_MAP, row_t'(9), '0);
		send_cmd(ACT_MAP, row_t'(10), '0);
		send_cmd(ACT_MAP, ROW_MAX, '0);
		// row groups: end before start, empty, normal, offset saturation
		send_cmd(ACT_RANGE, row_t'(30), row_t'(29));
		send_cmd(ACT_RANGE, '0, '0);
		send_cmd(ACT_RANGE, '0, row_t'(25));
		send_cmd(ACT_RANGE, '0, ROW_MAX);
		send_cmd(ACT_RANGE, ROW_MAX, ROW_MAX);
		send_cmd(ACT_CLEAR, '0, '0);
		send_cmd(ACT_MAP, row_t'(7), '0);

		// random sessions; hold the receiver off early on
		pressure_req = 1'b1;
		while (items_sent < ITEM_TARGET) begin
			if (!fill_done && items_sent >= 300) begin
				fill_table();
				fill_done = 1'b1;
			end else begin
				run_session();
			end
		end

		// drain
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatch_count == 0 && pending_results == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
